[hdl/rle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

  localparam int MAX_NODES = 256;

  localparam int UID_W   = 8;
  localparam int HOPS_W  = 10;
  localparam int RING_W  = 9;
  localparam int ROUND_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [HOPS_W-1:0]  HOPS_MAX    = 10'd512;
  localparam logic [ROUND_W-1:0] ROUND_MAX   = 4'd15;
  localparam logic [ROUND_W-1:0] ROUND_SAT   = 4'd9;
  localparam logic [RING_W-1:0]  RING_RESET  = 9'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_MSG   = 1'b1;

  localparam logic [1:0] KIND_OUT     = 2'd0;
  localparam logic [1:0] KIND_IN      = 2'd1;
  localparam logic [1:0] KIND_ELECTED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_UID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [1:0]        msg_kind;
    logic [UID_W-1:0]  msg_uid;
    logic [HOPS_W-1:0] msg_hops;
    logic              from_left;
  } in_item_t;

  typedef struct packed {
    logic              send_valid;
    logic              to_next;
    logic [1:0]        send_kind;
    logic [UID_W-1:0]  send_uid;
    logic [HOPS_W-1:0] send_hops;
    logic              leader_known;
    logic [UID_W-1:0]  leader_uid;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic               send_valid;
    logic               to_next;
    logic [1:0]         send_kind;
    logic [UID_W-1:0]   send_uid;
    logic [HOPS_W-1:0]  send_hops;
  } msg_t;

  typedef struct packed {
    msg_t m0;
    msg_t m1;
  } step_res_t;

  typedef struct packed {
    logic [ROUND_W-1:0] round;
    logic               got_reply_left;
    logic               got_reply_right;
    logic               leader_valid;
    logic [UID_W-1:0]   leader_value;
  } node_state_t;

  typedef struct packed {
    logic [UID_W-1:0]  own_uid;
    logic [RING_W-1:0] ring_size;
  } node_cfg_t;

endpackage

`default_nettype wire

[hdl/rle_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rle_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rle_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rle_pkg::node_cfg_t                  cfg
);
  import rle_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_uid   <= '0;
      cfg.ring_size <= RING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_UID:   cfg.own_uid   <= cfg_wdata[UID_W-1:0];
        CFG_RING_SIZE: cfg.ring_size <= cfg_wdata[RING_W-1:0];
        default:       ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/rle_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module rle_step (
  input  rle_pkg::in_item_t    item,
  input  rle_pkg::node_state_t st,
  input  rle_pkg::node_cfg_t   cfg,
  output rle_pkg::node_state_t st_next,
  output rle_pkg::step_res_t   res
);
  import rle_pkg::*;

  // hop count of zero means no message; above the limit it saturates
  function automatic msg_t mk_msg(input logic nxt, input logic [1:0] kind,
                                  input logic [UID_W-1:0] uid,
                                  input logic [HOPS_W-1:0] hops);
    msg_t m;
    m = '0;
    if (hops != '0) begin
      m.send_valid = 1'b1;
      m.to_next    = nxt;
      m.send_kind  = kind;
      m.send_uid   = uid;
      m.send_hops  = (hops > HOPS_MAX) ? HOPS_MAX : hops;
    end
    return m;
  endfunction

  logic [UID_W-1:0]   me;
  logic [HOPS_W-1:0]  ann_hops;
  logic [HOPS_W-1:0]  hops_dec;
  logic [ROUND_W-1:0] round_inc;
  logic [HOPS_W-1:0]  probe_hops;
  logic               uid_gt;
  logic               uid_eq;

  assign me       = cfg.own_uid;
  assign uid_gt   = item.msg_uid > me;
  assign uid_eq   = item.msg_uid == me;
  assign hops_dec = item.msg_hops - HOPS_W'(1);
  assign ann_hops = ({1'b0, cfg.ring_size} > HOPS_W'(MAX_NODES)) ?
                    HOPS_W'(MAX_NODES) : {1'b0, cfg.ring_size};
  assign round_inc  = (st.round == ROUND_MAX) ? st.round : st.round + ROUND_W'(1);
  assign probe_hops = (round_inc >= ROUND_SAT) ? HOPS_MAX : (HOPS_W'(1) << round_inc);

  always_comb begin
    st_next = st;
    res     = '0;
    case (item.command)
      CMD_START: begin
        if (cfg.ring_size <= RING_W'(1)) begin
          st_next.leader_valid = 1'b1;
          st_next.leader_value = me;
        end else begin
          res.m0 = mk_msg(1'b1, KIND_OUT, me, HOPS_W'(1));
          res.m1 = mk_msg(1'b0, KIND_OUT, me, HOPS_W'(1));
        end
      end
      CMD_MSG: begin
        case (item.msg_kind)
          KIND_OUT: begin
            if (uid_gt && item.msg_hops > HOPS_W'(1)) begin
              res.m0 = mk_msg(item.from_left, KIND_OUT, item.msg_uid, hops_dec);
            end else if (uid_gt && item.msg_hops == HOPS_W'(1)) begin
              res.m0 = mk_msg(!item.from_left, KIND_IN, item.msg_uid, HOPS_W'(1));
            end else if (uid_eq) begin
              st_next.leader_valid = 1'b1;
              st_next.leader_value = me;
              res.m0 = mk_msg(1'b1, KIND_ELECTED, me, ann_hops);
            end
          end
          KIND_IN: begin
            if (uid_eq) begin
              if (item.from_left) begin
                st_next.got_reply_left = 1'b1;
              end else begin
                st_next.got_reply_right = 1'b1;
              end
            end else begin
              res.m0 = mk_msg(item.from_left, KIND_IN, item.msg_uid, item.msg_hops);
            end
            if (st_next.got_reply_left && st_next.got_reply_right) begin
              st_next.round           = round_inc;
              st_next.got_reply_left  = 1'b0;
              st_next.got_reply_right = 1'b0;
              res.m0 = mk_msg(1'b1, KIND_OUT, me, probe_hops);
              res.m1 = mk_msg(1'b0, KIND_OUT, me, probe_hops);
            end
          end
          KIND_ELECTED: begin
            if (uid_gt) begin
              st_next.leader_valid = 1'b1;
              st_next.leader_value = item.msg_uid;
              if (item.msg_hops > HOPS_W'(1)) begin
                res.m0 = mk_msg(1'b1, KIND_ELECTED, item.msg_uid, hops_dec);
              end
            end else if (!uid_eq) begin
              res.m0 = mk_msg(1'b1, KIND_OUT, me, HOPS_W'(1));
              res.m1 = mk_msg(1'b0, KIND_OUT, me, HOPS_W'(1));
            end else begin
              st_next.leader_valid = 1'b1;
              st_next.leader_value = me;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/rle_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module rle_emit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     take,
  input  rle_pkg::step_res_t            res,
  input  wire logic                     leader_known,
  input  wire logic [rle_pkg::UID_W-1:0] leader_uid,
  output logic                          pair_ready,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output rle_pkg::out_item_t            out_data
);
  import rle_pkg::*;

  logic      slot_valid;
  out_item_t slot_data;
  out_item_t r0;
  out_item_t r1;

  assign pair_ready = !slot_valid && (!out_valid || !out_stall);

  always_comb begin
    r0 = {res.m0, leader_known, leader_uid, !res.m1.send_valid};
    r1 = {res.m1, leader_known, leader_uid, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      slot_valid <= 1'b0;
    end else if (take) begin
      out_valid  <= 1'b1;
      slot_valid <= res.m1.send_valid;
    end else if (out_valid && !out_stall) begin
      out_valid  <= slot_valid;
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data  <= r0;
      slot_data <= r1;
    end else if (out_valid && !out_stall && slot_valid) begin
      out_data <= slot_data;
    end
  end

endmodule

`default_nettype wire

[hdl/ring_leader_election_node_core.sv]
// Channel | Direction | Signals                        | Transaction
// in      | input     | in_valid, in_stall, in_data    | in_valid && !in_stall
// out     | output    | out_valid, out_stall, out_data | out_valid && !out_stall
// cfg     | input     | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// An accepted item is held in the input register, then goes through the combinational
// step logic into the output register.
// Results leave through the single output port; an item with two results blocks the next one.
// Reset (rst, synchronous) clears election state and valids; configuration goes to UID 0, ring size 2.
// A stalled output holds its result; in_stall rises while an item waits and the output stage cannot take it.
`timescale 1ns / 1ps
`default_nettype none

module ring_leader_election_node_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  rle_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output rle_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rle_pkg::*;

  node_cfg_t   cfg;
  node_state_t st;
  node_state_t st_next;
  step_res_t   res;
  in_item_t    item;
  logic        item_valid;
  logic        pair_ready;
  logic        take;

  assign take     = item_valid && pair_ready;
  assign in_stall = item_valid && !pair_ready;

  rle_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  rle_step u_step (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  rle_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .res          (res),
    .leader_known (st_next.leader_valid),
    .leader_uid   (st_next.leader_value),
    .pair_ready   (pair_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

`ifndef ASSERT_OFF
  a_flags_never_both: assert property (@(posedge clk) disable iff (rst)
    !(st.got_reply_left && st.got_reply_right))
    else $error("both reply flags held in state");

  a_round_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> st.round >= $past(st.round))
    else $error("round decreased");

  a_leader_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(st.leader_valid))
    else $error("leader lost");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=> out_valid && out_data.last)
    else $error("second result of a transaction missing");
`endif

endmodule

`default_nettype wire
